// File: hw/rtl/terminal_line_editor_unit_defines.svh
// Assertion macros shared by the line editor RTL.
// Needs aclk and aresetn in the scope of each use.
`ifndef TERMINAL_LINE_EDITOR_UNIT_DEFINES_SVH
`define TERMINAL_LINE_EDITOR_UNIT_DEFINES_SVH

`define TLE_ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

`define TLE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/tle_pkg.sv
// Shared constants and types of the terminal line editor.
// No dependencies; used by tle_decode and terminal_line_editor_unit.
package tle_pkg;

    localparam logic [7:0] CH_DEL      = 8'h7F;
    localparam logic [7:0] CH_ESC      = 8'h1B;
    localparam logic [7:0] CH_BS       = 8'h08;
    localparam logic [7:0] CH_CR       = 8'h0D;
    localparam logic [7:0] CH_LF       = 8'h0A;
    localparam logic [7:0] CH_SP       = 8'h20;
    localparam logic [7:0] CH_LBRACKET = 8'h5B;
    localparam logic [7:0] CH_A        = 8'h41;
    localparam logic [7:0] CH_D        = 8'h44;
    localparam logic [7:0] CH_NUL      = 8'h00;

    localparam logic [7:0] LIMIT_RESET = 8'd64;
    localparam logic [7:0] COUNT_MAX   = 8'hFF;

    localparam logic [1:0] ESC_NONE = 2'd0;
    localparam logic [1:0] ESC_SEEN = 2'd1;
    localparam logic [1:0] ESC_CSI  = 2'd2;

    localparam int OUT_W = 40;

    typedef enum logic [1:0] {
        KIND_CHAR = 2'd0,
        KIND_BS   = 2'd1,
        KIND_LF   = 2'd2
    } kind_t;

    typedef struct packed {
        logic [1:0] esc_phase;
        logic [7:0] line_count;
    } edit_state_t;

    typedef struct packed {
        logic       emit;
        kind_t      kind;
        logic [7:0] echo_char;
        logic       store_valid;
        logic [7:0] store_index;
        logic [7:0] store_char;
        logic       overflow;
        logic [7:0] length;
    } res_desc_t;

endpackage

// File: hw/rtl/terminal_line_editor_unit.sv
// Terminal line editor: one received byte in, up to three echo/store requests out.
// The first result is registered and offered in the cycle after the byte is accepted.
// The output register gives one result per cycle while m_tready is high; a backspace
// gives three results, a line feed two, any other echoed byte one, a dropped byte none.
// A new byte is taken in the cycle the final result of the previous one leaves.
// Reset (aresetn low, synchronous): line length 0, no escape sequence, limit 64.
`include "terminal_line_editor_unit_defines.svh"

module terminal_line_editor_unit
    import tle_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,

    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [7:0]       s_tdata,   // [7:0] raw_byte

    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [OUT_W-1:0] m_tdata,   // [0] echo_valid, [8:1] echo_byte,
                                        // [9] store_valid, [17:10] store_index,
                                        // [25:18] store_char, [26] line_done,
                                        // [27] line_overflow, [35:28] line_length
    output logic             m_tlast,

    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [7:0]       cfg_data   // [7:0] line_limit
);

    edit_state_t state_reg;
    edit_state_t state_next;
    res_desc_t   desc_reg;
    res_desc_t   desc_next;
    logic        busy_reg;
    logic        busy_next;
    logic [1:0]  pos_reg;
    logic [1:0]  pos_next;
    logic [7:0]  limit_reg;

    logic        s_fire;
    logic        m_fire;
    logic        at_last;
    logic [1:0]  last_pos;
    logic        first;
    logic [7:0]  echo_byte;
    logic        line_done;

    tle_decode u_decode (
        .raw_byte   (s_tdata),
        .line_limit (limit_reg),
        .cur_state  (state_reg),
        .next_state (state_next),
        .desc       (desc_next)
    );

    always_comb begin
        case (desc_reg.kind)
            KIND_BS: last_pos = 2'd2;
            KIND_LF: last_pos = 2'd1;
            default: last_pos = 2'd0;
        endcase
    end

    assign at_last   = (pos_reg == last_pos);
    assign m_fire    = busy_reg && m_tready;
    assign s_tready  = !busy_reg || (m_tready && at_last);
    assign s_fire    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    always_comb begin
        busy_next = busy_reg;
        pos_next  = pos_reg;
        if (m_fire) begin
            if (at_last) begin
                busy_next = 1'b0;
            end else begin
                pos_next = pos_reg + 2'd1;
            end
        end
        if (s_fire && desc_next.emit) begin
            busy_next = 1'b1;
            pos_next  = 2'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '0;
            busy_reg  <= 1'b0;
            pos_reg   <= 2'd0;
            limit_reg <= LIMIT_RESET;
        end else begin
            busy_reg <= busy_next;
            pos_reg  <= pos_next;
            if (s_fire) begin
                state_reg <= state_next;
            end
            if (cfg_valid && cfg_ready) begin
                limit_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire && desc_next.emit) begin
            desc_reg <= desc_next;
        end
    end

    always_comb begin
        first = (pos_reg == 2'd0);
        case (desc_reg.kind)
            KIND_BS: echo_byte = (pos_reg == 2'd1) ? CH_SP : CH_BS;
            KIND_LF: echo_byte = first ? CH_LF : CH_CR;
            default: echo_byte = desc_reg.echo_char;
        endcase
        line_done = first && (desc_reg.kind == KIND_LF);
    end

    assign m_tvalid = busy_reg;
    assign m_tlast  = at_last;
    assign m_tdata  = {4'b0,
                       line_done ? desc_reg.length : 8'd0,
                       line_done && desc_reg.overflow,
                       line_done,
                       first ? desc_reg.store_char : 8'd0,
                       first ? desc_reg.store_index : 8'd0,
                       first && desc_reg.store_valid,
                       echo_byte,
                       1'b1};

    `TLE_ASSERT_IMPLIES(a_hold_input, busy_reg && !(m_tready && at_last), !s_tready, "input taken while results pending")
    `TLE_ASSERT_IMPLIES(a_store_in_limit, m_tvalid && m_tdata[9], m_tdata[17:10] < limit_reg, "store beyond line limit")
    `TLE_ASSERT_NEXT(a_load_first, s_fire && desc_next.emit, m_tvalid && pos_reg == 2'd0, "new result set not at first slot")
    `TLE_ASSERT_IMPLIES(a_done_on_lf, m_tvalid && m_tdata[26], desc_reg.kind == KIND_LF && !m_tlast, "line status outside first line feed result")

endmodule

// File: hw/rtl/tle_decode.sv
// Byte mapping, escape filter and line bookkeeping for one received byte.
// Combinational; depends on tle_pkg.
module tle_decode
    import tle_pkg::*;
(
    input  logic [7:0]  raw_byte,
    input  logic [7:0]  line_limit,
    input  edit_state_t cur_state,
    output edit_state_t next_state,
    output res_desc_t   desc
);

    logic [7:0] c;
    logic       drop;
    logic [8:0] count_inc;

    always_comb begin
        c = raw_byte;
        if (raw_byte == CH_DEL) begin
            c = CH_BS;
        end else if (raw_byte == CH_CR) begin
            c = CH_LF;
        end

        drop       = 1'b0;
        next_state = cur_state;
        count_inc  = {1'b0, cur_state.line_count} + 9'd1;
        desc       = '0;
        desc.kind  = KIND_CHAR;

        if (c == CH_ESC) begin
            next_state.esc_phase = ESC_SEEN;
            drop = 1'b1;
        end else if (cur_state.esc_phase == ESC_SEEN) begin
            if (c == CH_LBRACKET) begin
                next_state.esc_phase = ESC_CSI;
                drop = 1'b1;
            end else begin
                next_state.esc_phase = ESC_NONE;
            end
        end else if (cur_state.esc_phase != ESC_NONE) begin
            next_state.esc_phase = ESC_NONE;
            if (c >= CH_A && c <= CH_D) begin
                drop = 1'b1;
            end
        end

        if (!drop) begin
            if (c == CH_BS) begin
                if (cur_state.line_count != 8'd0) begin
                    desc.emit  = 1'b1;
                    desc.kind  = KIND_BS;
                    next_state.line_count = cur_state.line_count - 8'd1;
                end
            end else if (c == CH_LF) begin
                desc.emit     = 1'b1;
                desc.kind     = KIND_LF;
                desc.length   = cur_state.line_count;
                desc.overflow = !(cur_state.line_count < line_limit);
                if (cur_state.line_count < line_limit) begin
                    desc.store_valid = 1'b1;
                    desc.store_index = cur_state.line_count;
                    desc.store_char  = CH_NUL;
                end
                next_state.line_count = 8'd0;
            end else begin
                desc.emit      = 1'b1;
                desc.kind      = KIND_CHAR;
                desc.echo_char = c;
                if (count_inc < {1'b0, line_limit}) begin
                    desc.store_valid = 1'b1;
                    desc.store_index = cur_state.line_count;
                    desc.store_char  = c;
                end
                if (cur_state.line_count != COUNT_MAX) begin
                    next_state.line_count = count_inc[7:0];
                end
            end
        end
    end

endmodule

// File: tb/terminal_line_editor_unit_tb.sv
// Self-checking testbench for terminal_line_editor_unit: byte stream in, echo/store requests out.
// Needs tle_pkg and the RTL top; predicts each request and compares it field by field.
`timescale 1ns / 1ps

module terminal_line_editor_unit_tb;
    import tle_pkg::*;

    typedef struct packed {
        logic       echo_valid;
        logic [7:0] echo_byte;
        logic       store_valid;
        logic [7:0] store_index;
        logic [7:0] store_char;
        logic       line_done;
        logic       line_overflow;
        logic [7:0] line_length;
        logic       last;
    } line_request_t;

    logic             aclk;
    logic             aresetn   = 1'b0;
    logic             s_tvalid  = 1'b0;
    logic             s_tready;
    logic [7:0]       s_tdata   = 8'h00;
    logic             m_tvalid;
    logic             m_tready  = 1'b0;
    logic [OUT_W-1:0] m_tdata;
    logic             m_tlast;
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    logic [7:0]       cfg_data  = 8'h00;

    line_request_t pending_requests [$];
    line_request_t want;

    logic [7:0] line_limit = LIMIT_RESET;
    logic [7:0] line_len   = 8'd0;
    logic [1:0] esc_phase  = ESC_NONE;

    int src_idle_pct     = 0;
    int snk_stall_pct    = 0;
    int bytes_sent       = 0;
    int bytes_dropped    = 0;
    int requests_checked = 0;
    int lines_done       = 0;
    int lines_overflowed = 0;
    int mismatches       = 0;

    terminal_line_editor_unit u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    initial begin
        #400000;
        $display("terminal_line_editor_unit_tb: FAIL");
        $finish;
    end

    function automatic line_request_t echo_req(input logic [7:0] b);
        line_request_t r;
        r            = '0;
        r.echo_valid = 1'b1;
        r.echo_byte  = b;
        return r;
    endfunction

    function automatic void edit_byte(input logic [7:0] raw);
        logic [7:0]    c;
        line_request_t r0;
        line_request_t r1;
        line_request_t r2;
        c = raw;
        if (c == CH_DEL) begin
            c = CH_BS;
        end else if (c == CH_CR) begin
            c = CH_LF;
        end
        if (c == CH_ESC) begin
            esc_phase = ESC_SEEN;
            bytes_dropped++;
            return;
        end
        if (esc_phase == ESC_SEEN) begin
            if (c == CH_LBRACKET) begin
                esc_phase = ESC_CSI;
                bytes_dropped++;
                return;
            end
            esc_phase = ESC_NONE;
        end else if (esc_phase != ESC_NONE) begin
            esc_phase = ESC_NONE;
            if (c >= CH_A && c <= CH_D) begin
                bytes_dropped++;
                return;
            end
        end
        if (c == CH_BS && line_len == 8'd0) begin
            bytes_dropped++;
            return;
        end
        if (c == CH_BS) begin
            r0      = echo_req(CH_BS);
            r1      = echo_req(CH_SP);
            r2      = echo_req(CH_BS);
            r2.last = 1'b1;
            pending_requests.push_back(r0);
            pending_requests.push_back(r1);
            pending_requests.push_back(r2);
            line_len = line_len - 8'd1;
        end else if (c == CH_LF) begin
            r0             = echo_req(CH_LF);
            r0.line_done   = 1'b1;
            r0.line_length = line_len;
            if (line_len < line_limit) begin
                r0.store_valid = 1'b1;
                r0.store_index = line_len;
                r0.store_char  = CH_NUL;
            end else begin
                r0.line_overflow = 1'b1;
                lines_overflowed++;
            end
            r1      = echo_req(CH_CR);
            r1.last = 1'b1;
            pending_requests.push_back(r0);
            pending_requests.push_back(r1);
            lines_done++;
            line_len = 8'd0;
        end else begin
            r0      = echo_req(c);
            r0.last = 1'b1;
            if ({1'b0, line_len} + 9'd1 < {1'b0, line_limit}) begin
                r0.store_valid = 1'b1;
                r0.store_index = line_len;
                r0.store_char  = c;
            end
            pending_requests.push_back(r0);
            if (line_len != COUNT_MAX) begin
                line_len = line_len + 8'd1;
            end
        end
    endfunction

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= snk_stall_pct);
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_requests.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("unexpected request: tdata=%h tlast=%b", m_tdata, m_tlast);
                end
            end else begin
                want = pending_requests.pop_front();
                requests_checked++;
                if (!(m_tdata[0]     === want.echo_valid    &&
                      m_tdata[8:1]   === want.echo_byte     &&
                      m_tdata[9]     === want.store_valid   &&
                      m_tdata[17:10] === want.store_index   &&
                      m_tdata[25:18] === want.store_char    &&
                      m_tdata[26]    === want.line_done     &&
                      m_tdata[27]    === want.line_overflow &&
                      m_tdata[35:28] === want.line_length   &&
                      m_tdata[39:36] === 4'b0000            &&
                      m_tlast        === want.last)) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("mismatch on request %0d:", requests_checked);
                        $display("  want echo %b/%h store %b/%h/%h done %b ovf %b len %h last %b",
                                 want.echo_valid, want.echo_byte, want.store_valid,
                                 want.store_index, want.store_char, want.line_done,
                                 want.line_overflow, want.line_length, want.last);
                        $display({"  got  echo %b/%h store %b/%h/%h done %b ovf %b len %h",
                                  " last %b pad %h"},
                                 m_tdata[0], m_tdata[8:1], m_tdata[9], m_tdata[17:10],
                                 m_tdata[25:18], m_tdata[26], m_tdata[27], m_tdata[35:28],
                                 m_tlast, m_tdata[39:36]);
                    end
                end
            end
        end
    end

    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(posedge aclk); while (!s_tready);
        edit_byte(b);
        bytes_sent++;
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending_requests.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_limit(input logic [7:0] v);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid  <= 1'b0;
        line_limit  = v;
    endtask

    task automatic send_random_token();
        int pick;
        pick = $urandom_range(99);
        if (pick < 55) begin
            send_byte(8'($urandom_range(8'h7E, 8'h20)));
        end else if (pick < 67) begin
            send_byte($urandom_range(1) ? CH_BS : CH_DEL);
        end else if (pick < 77) begin
            send_byte($urandom_range(1) ? CH_LF : CH_CR);
        end else if (pick < 87) begin
            send_byte(CH_ESC);
            case ($urandom_range(3))
                0: begin
                    send_byte(CH_LBRACKET);
                    send_byte(8'($urandom_range(CH_D, CH_A)));
                end
                1: begin
                    send_byte(CH_LBRACKET);
                    send_byte(8'($urandom_range(255)));
                end
                2: send_byte(8'($urandom_range(255)));
                default: send_byte(CH_ESC);
            endcase
        end else begin
            send_byte(8'($urandom_range(255)));
        end
    endtask

    task automatic test_directed_bytes();
        send_byte(CH_BS);
        send_byte(CH_DEL);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h80);
        send_byte(8'h55);
        send_byte(8'hAA);
        send_byte(CH_BS);
        send_byte(CH_DEL);
        send_byte(CH_ESC);
        send_byte(CH_LBRACKET);
        send_byte(CH_A);
        send_byte(CH_ESC);
        send_byte(CH_LBRACKET);
        send_byte(CH_D);
        send_byte(CH_ESC);
        send_byte(CH_LBRACKET);
        send_byte(CH_D + 8'd1);
        send_byte(CH_ESC);
        send_byte(8'h78);
        send_byte(CH_ESC);
        send_byte(CH_ESC);
        send_byte(CH_LBRACKET);
        send_byte(CH_ESC);
        send_byte(CH_DEL);
        send_byte(CH_CR);
        send_byte(CH_LF);
    endtask

    task automatic test_limit_extremes();
        write_limit(8'd1);
        send_byte(8'h61);
        send_byte(CH_CR);
        send_byte(CH_LF);
        write_limit(8'd0);
        send_byte(8'h62);
        send_byte(CH_LF);
        send_byte(CH_LF);
        write_limit(8'd255);
        send_byte(8'h63);
        send_byte(CH_LF);
    endtask

    task automatic test_length_saturation();
        int i;
        write_limit(8'd255);
        src_idle_pct  = 22;
        snk_stall_pct = 22;
        send_byte(CH_CR);
        for (i = 0; i < 258; i++) begin
            send_byte($urandom_range(1) ? 8'($urandom_range(8'h7E, 8'h20))
                                        : 8'($urandom_range(8'hFF, 8'h80)));
        end
        send_byte(CH_BS);
        send_byte(CH_DEL);
        send_byte(8'h41);
        send_byte(8'h42);
        send_byte(CH_LF);
    endtask

    task automatic test_random_traffic(input int src_pct, input int snk_pct,
                                       input logic [7:0] limit, input int count);
        int start;
        write_limit(limit);
        src_idle_pct  = src_pct;
        snk_stall_pct = snk_pct;
        start         = bytes_sent;
        while (bytes_sent - start < count) begin
            send_random_token();
        end
    endtask

    initial begin
        aresetn <= 1'b0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed_bytes();
        test_limit_extremes();
        test_random_traffic(0, 0, 8'd8, 30);
        test_random_traffic(82, 0, 8'($urandom_range(20, 2)), 30);
        test_random_traffic(0, 82, 8'($urandom_range(12, 3)), 30);
        test_random_traffic(22, 22, LIMIT_RESET, 30);
        test_length_saturation();
        test_random_traffic(0, 0, 8'd1, 10);

        wait_idle();
        $display("terminal_line_editor_unit_tb: %0d bytes sent (%0d dropped), %0d requests checked",
                 bytes_sent, bytes_dropped, requests_checked);
        $display("terminal_line_editor_unit_tb: %0d lines ended, %0d overflowed, limits 0/1/255",
                 lines_done, lines_overflowed);
        if (mismatches == 0 && pending_requests.size() == 0) begin
            $display("terminal_line_editor_unit_tb: PASS");
        end else begin
            $display("terminal_line_editor_unit_tb: FAIL");
        end
        $finish;
    end

endmodule

// File: sim.f
+incdir+hw/rtl
hw/rtl/tle_pkg.sv
hw/rtl/tle_decode.sv
hw/rtl/terminal_line_editor_unit.sv
tb/terminal_line_editor_unit_tb.sv
